### rtl/mdpa_pkg.sv
// ----------------------------------------------------------------------------
// mdpa_pkg
// Shared widths, prime constants and controller/datapath command types for
// the modular dot-product accumulator.
// ----------------------------------------------------------------------------
package mdpa_pkg;

    // field widths
    localparam int unsigned VAL_W     = 30;          // operands, residues, sum
    localparam int unsigned PROD_W    = 2 * VAL_W;   // full product a*b
    localparam int unsigned MUL_W     = 31;          // shared multiplier operand
    localparam int unsigned MUL_P_W   = 2 * MUL_W;   // shared multiplier product
    localparam int unsigned RED_W     = 32;          // Barrett remainder, below 3q
    localparam int unsigned SHIFT_IN  = 29;
    localparam int unsigned SHIFT_OUT = 31;

    // moduli and Barrett constants, mu = floor(2^60 / q)
    localparam logic [VAL_W-1:0] PRIME_A = 30'd1073738753;
    localparam logic [VAL_W-1:0] PRIME_B = 30'd1073732609;
    localparam logic [MUL_W-1:0] MU_A    = 31'd1073744895;
    localparam logic [MUL_W-1:0] MU_B    = 31'd1073751039;

    // command from controller to datapath, one step per field
    typedef struct packed {
        logic load;   // capture term, form a*b
        logic mul2;   // form (x >> 29) * mu
        logic mul3;   // form qhat * q
        logic red;    // subtract and correct
        logic acc;    // add into sum, emit on last term
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last;       // term in flight closes the dot product
        logic out_busy;   // result register full and not taken this cycle
    } t_dp_sts;

    function automatic logic [VAL_W-1:0] prime_q(input logic sel);
        return sel ? PRIME_B : PRIME_A;
    endfunction

    function automatic logic [MUL_W-1:0] prime_mu(input logic sel);
        return sel ? MU_B : MU_A;
    endfunction

endpackage

### rtl/mdpa_if.sv
// ----------------------------------------------------------------------------
// mdpa_if
// Valid/ready channels of the modular dot-product accumulator: one term
// channel in, one result channel out.
// ----------------------------------------------------------------------------
interface mdpa_term_if import mdpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] row_value;
    logic [VAL_W-1:0] weight_value;
    logic             last_term;

    modport source (output valid, output row_value, output weight_value,
                    output last_term, input ready);
    modport sink   (input valid, input row_value, input weight_value,
                    input last_term, output ready);
endinterface

interface mdpa_result_if import mdpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] dot_result;

    modport source (output valid, output dot_result, input ready);
    modport sink   (input valid, input dot_result, output ready);
endinterface

### rtl/mdpa_ctrl.sv
// ----------------------------------------------------------------------------
// mdpa_ctrl
// Sequencer: steps each term through the three passes of the shared
// multiplier, the reduction and the accumulate.
// ----------------------------------------------------------------------------
module mdpa_ctrl import mdpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL2,
        S_MUL3,
        S_RED,
        S_ACC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc_done;
    logic   xfer;

    // a closing term waits while the result register is still full
    assign acc_done   = !(i_sts.last && i_sts.out_busy);
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_ACC) && acc_done);
    assign xfer       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load = xfer;
        o_cmd.mul2 = (r_state == S_MUL2);
        o_cmd.mul3 = (r_state == S_MUL3);
        o_cmd.red  = (r_state == S_RED);
        o_cmd.acc  = (r_state == S_ACC) && acc_done;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (xfer) n_state = S_MUL2;
            end
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_RED;
            S_RED:  n_state = S_ACC;
            S_ACC: begin
                if (acc_done) n_state = xfer ? S_MUL2 : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> (r_state == S_MUL2))
        else $error("accepted term did not enter second multiply pass");

    a_acc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACC) && !acc_done) |=> (r_state == S_ACC))
        else $error("stalled accumulate step left before result was taken");

    a_mul_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !(o_cmd.mul2 || o_cmd.mul3 || o_cmd.red))
        else $error("multiplier claimed by load while a term is in flight");

endmodule

### rtl/mdpa_dp.sv
// ----------------------------------------------------------------------------
// mdpa_dp
// Datapath: shared 31x31 multiplier, Barrett correction, modular accumulator,
// prime select register and result register.
// ----------------------------------------------------------------------------
module mdpa_dp import mdpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic [VAL_W-1:0] i_row_value,
    input  logic [VAL_W-1:0] i_weight_value,
    input  logic             i_last_term,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [VAL_W-1:0] o_dot_result,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    logic               r_prime_sel;
    logic [VAL_W-1:0]   r_sum;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_data;
    logic [PROD_W-1:0]  r_x;
    logic [MUL_P_W-1:0] r_m;
    logic [VAL_W-1:0]   r_red;
    logic               r_last;

    logic [VAL_W-1:0]   q;
    logic [MUL_W-1:0]   mu;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [RED_W-1:0]   red_r;
    logic [RED_W-1:0]   red_v;
    logic [RED_W-1:0]   q1;
    logic [RED_W-1:0]   q2;
    logic [VAL_W:0]     acc_s;
    logic [VAL_W:0]     acc_v;

    assign q  = prime_q(r_prime_sel);
    assign mu = prime_mu(r_prime_sel);

    // one multiplier, three passes per term
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.load) begin
            mul_a = {1'b0, i_row_value};
            mul_b = {1'b0, i_weight_value};
        end else if (i_cmd.mul2) begin
            mul_a = r_x[SHIFT_IN +: MUL_W];
            mul_b = mu;
        end else if (i_cmd.mul3) begin
            mul_a = r_m[SHIFT_OUT +: MUL_W];
            mul_b = {1'b0, q};
        end
    end

    assign mul_p = mul_a * mul_b;

    // remainder is below 3q, so low 32 bits carry it exactly
    assign q1    = {{(RED_W-VAL_W){1'b0}}, q};
    assign q2    = {{(RED_W-VAL_W-1){1'b0}}, q, 1'b0};
    assign red_r = r_x[RED_W-1:0] - r_m[RED_W-1:0];

    always_comb begin
        if (red_r >= q2) begin
            red_v = red_r - q2;
        end else if (red_r >= q1) begin
            red_v = red_r - q1;
        end else begin
            red_v = red_r;
        end
    end

    assign acc_s = {1'b0, r_sum} + {1'b0, r_red};
    assign acc_v = (acc_s >= {1'b0, q}) ? (acc_s - {1'b0, q}) : acc_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_sel <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_prime_sel <= i_cfg_wdata;
            if (i_cmd.acc) r_sum <= r_last ? '0 : acc_v[VAL_W-1:0];
            if (i_cmd.acc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= mul_p[PROD_W-1:0];
            r_last <= i_last_term;
        end
        if (i_cmd.mul2 || i_cmd.mul3) r_m <= mul_p;
        if (i_cmd.red) r_red <= red_v[VAL_W-1:0];
        if (i_cmd.acc && r_last) r_out_data <= acc_v[VAL_W-1:0];
    end

    assign o_out_valid   = r_out_valid;
    assign o_dot_result  = r_out_data;
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.acc && r_last))
        else $error("result appeared without a closing accumulate");

endmodule

### rtl/modular_dot_product_accumulate.sv
// ----------------------------------------------------------------------------
// modular_dot_product_accumulate
// Dot product of 30-bit residues modulo a selectable prime: each term is
// multiplied, Barrett-reduced and added to a running sum modulo q.
// ----------------------------------------------------------------------------
//
//   channel   dir  signals                                 transfer
//   i_term    in   row_value, weight_value, last_term      valid && ready
//   o_result  out  dot_result                              valid && ready
//   i_cfg     in   i_cfg_we, i_cfg_wdata (prime_select)    i_cfg_we
//
// Sequence: a term runs from its transfer through a*b, (x>>29)*mu, qhat*q,
//   correction and accumulate; the next term transfers in the accumulate
//   step, so a new term is taken only when the previous one reaches that step,
//   a pace set by the three passes through the one shared 31x31 multiplier and
//   the correction step.
// Reset: synchronous, active low; clears the sum, prime select and result valid.
// Stalls: the result register holds until taken; a closing term whose result
//   register is still full waits in the accumulate step and holds off i_term.
// ----------------------------------------------------------------------------
module modular_dot_product_accumulate import mdpa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    mdpa_term_if.sink     i_term,
    mdpa_result_if.source o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence the shared multiplier and the accumulate step
    mdpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_term.valid),
        .o_in_ready (i_term.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic, sum, prime select and result register
    mdpa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_row_value    (i_term.row_value),
        .i_weight_value (i_term.weight_value),
        .i_last_term    (i_term.last_term),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_dot_result   (o_result.dot_result),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
